/* design/spi_slave_block_bridge_core_defines.svh */
// Assertion macros for the SPI slave block bridge.
// Used by the top level only; no other dependencies.
`ifndef SPI_SLAVE_BLOCK_BRIDGE_CORE_DEFINES_SVH
`define SPI_SLAVE_BLOCK_BRIDGE_CORE_DEFINES_SVH

// same-cycle implication
`define SSBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("ssbb: assertion failed");

// next-cycle implication
`define SSBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("ssbb: assertion failed");

`endif

/* design/ssbb_pkg.sv */
// Shared types and constants of the SPI slave block bridge.
// No dependencies; imported by every module of the block except ssbb_ram.
package ssbb_pkg;

	// FIFO_DEPTH must be a power of two (pointers wrap naturally)
	localparam int FIFO_DEPTH = 1024;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;
	localparam int LEVEL_W    = 11;
	localparam int MAX_BLOCK  = 32;
	localparam int BUF_DEPTH  = MAX_BLOCK + 1;
	localparam int BUF_AW     = $clog2(BUF_DEPTH);
	localparam int LEN_W      = 6;

	localparam logic [7:0] ST_BASE      = 8'h50;
	localparam logic [7:0] ST_OUT_EMPTY = 8'h01;
	localparam logic [7:0] ST_IN_FULL   = 8'h02;
	localparam logic [7:0] ST_LEN_ERR   = 8'h04;
	localparam logic [7:0] ST_CHK_ERR   = 8'h08;

	localparam logic [4:0] CMD_NONE   = 5'd0;
	localparam logic [4:0] CMD_STATUS = 5'd1;
	localparam logic [4:0] CMD_READ   = 5'd10;
	localparam logic [4:0] CMD_WRITE  = 5'd20;
	localparam logic [4:0] CMD_SETLEN = 5'd30;

	localparam logic [LEN_W-1:0] LEN_DEFAULT = (MAX_BLOCK >= 16) ? LEN_W'(16) : LEN_W'(8);

	typedef enum logic [1:0] {
		OP_SPI  = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_RESP, PH_SETLEN, PH_WDATA, PH_RDATA, PH_RTAIL, PH_MSTAT, PH_END
	} phase_t;

	typedef enum logic [3:0] {
		E_IDLE, E_EXEC, E_POPRD, E_BUFRD, E_FILL_RD, E_FILL_WR, E_APP_RD, E_APP_WR, E_DONE
	} eng_state_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_spi;
		logic       is_push;
		logic       is_pop;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               notify;
		logic               push_ok;
		logic               pop_valid;
		logic [7:0]         pop_byte;
		logic               load;
		logic [7:0]         tx;
	} res_t;

endpackage

/* design/ssbb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/ssbb_front.sv */
// Front end: accepts input transfers, classifies them, two-entry queue.
// Depends on ssbb_pkg.
module ssbb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_op,
	input  logic [7:0]    in_data,
	output logic          q_valid,
	output ssbb_pkg::item_t q_item,
	input  logic          q_take
);
	import ssbb_pkg::*;

	item_t      ent_q [2];
	item_t      cls;
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       enq, deq;

	always_comb begin
		cls      = '0;
		cls.data = in_data;
		unique case (op_t'(in_op))
			OP_SPI:  cls.is_spi  = 1'b1;
			OP_PUSH: cls.is_push = 1'b1;
			OP_POP:  cls.is_pop  = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];
	assign enq      = in_valid && in_ready;
	assign deq      = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wp_q] <= cls;
		end
	end
endmodule

/* design/ssbb_back.sv */
// Back end: command engine, FIFO bookkeeping, block buffer, output register.
// Depends on ssbb_pkg and ssbb_ram.
module ssbb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  ssbb_pkg::item_t q_item,
	output logic            q_take,
	output logic            out_valid,
	input  logic            out_ready,
	output ssbb_pkg::res_t  out_res
);
	import ssbb_pkg::*;

	eng_state_t state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [4:0] cmd_q, cmd_d;
	logic [LEN_W-1:0] blen_q, blen_d, idx_q, idx_d, k;
	logic       chk_q, chk_d, len_q, len_d, have_q, have_d;
	logic [7:0] xor_q, xor_d, resp_q, resp_d, st_now, b, resp_new, fill_v;
	logic [CNT_W-1:0]   in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
	logic [FIFO_AW-1:0] in_head_q, in_head_d, out_head_q, out_head_d;
	item_t item_q, item_d;
	res_t  res_q, res_d, out_q, out_d;
	logic  out_v_q, out_v_d;
	logic  room_short, rd_ok, wr_ok, cmd_ok, wlast, match, len_ok;

	logic               ib_we, ob_we, bf_we;
	logic [FIFO_AW-1:0] ib_waddr, ib_raddr, ob_waddr, ob_raddr;
	logic [BUF_AW-1:0]  bf_waddr, bf_raddr;
	logic [7:0]         ib_wdata, ib_rdata, ob_wdata, ob_rdata, bf_wdata, bf_rdata;

	ssbb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_inbound (
		.clk(clk), .we(ib_we), .waddr(ib_waddr), .wdata(ib_wdata),
		.raddr(ib_raddr), .rdata(ib_rdata)
	);
	ssbb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_outbound (
		.clk(clk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
		.raddr(ob_raddr), .rdata(ob_rdata)
	);
	ssbb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_block (
		.clk(clk), .we(bf_we), .waddr(bf_waddr), .wdata(bf_wdata),
		.raddr(bf_raddr), .rdata(bf_rdata)
	);

	// decisions
	always_comb begin
		b          = item_q.data;
		room_short = ({1'b0, in_cnt_q} + (CNT_W+1)'(blen_q)) > (CNT_W+1)'(FIFO_DEPTH);
		st_now     = ST_BASE;
		if (room_short)        st_now = st_now | ST_IN_FULL;
		if (out_cnt_q == '0)   st_now = st_now | ST_OUT_EMPTY;
		if (chk_q)             st_now = st_now | ST_CHK_ERR;
		if (len_q)             st_now = st_now | ST_LEN_ERR;
		rd_ok  = (b == 8'(CMD_READ)) && (out_cnt_q != '0);
		wr_ok  = (b == 8'(CMD_WRITE)) && !room_short;
		cmd_ok = (b == 8'(CMD_STATUS)) || (b == 8'(CMD_SETLEN)) || rd_ok || wr_ok;
		k      = (idx_q < blen_q) ? idx_q : blen_q;
		wlast  = !(idx_q < blen_q);
		match  = (b == xor_q);
		len_ok = ((b == 8'd8) || (b == 8'd16) || (b == 8'd32)) && (b <= 8'(MAX_BLOCK));
		fill_v = have_q ? ob_rdata : 8'h00;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: if (q_valid) state_d = E_EXEC;
			E_EXEC: begin
				state_d = E_DONE;
				if (item_q.is_pop && in_cnt_q != '0) state_d = E_POPRD;
				if (item_q.is_spi) begin
					unique case (phase_q)
						PH_IDLE:  if (rd_ok) state_d = E_FILL_RD;
						PH_RESP:  if (cmd_q == CMD_READ) state_d = E_BUFRD;
						PH_RDATA: state_d = E_BUFRD;
						PH_WDATA: if (wlast && match) state_d = E_APP_RD;
						default:  ;
					endcase
				end
			end
			E_POPRD, E_BUFRD: state_d = E_DONE;
			E_FILL_RD: state_d = (idx_q == blen_q) ? E_DONE : E_FILL_WR;
			E_FILL_WR: state_d = E_FILL_RD;
			E_APP_RD:  state_d = (idx_q == blen_q) ? E_DONE : E_APP_WR;
			E_APP_WR:  state_d = E_APP_RD;
			E_DONE:    if (!out_v_q || out_ready) state_d = E_IDLE;
			default:   state_d = E_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		phase_d    = phase_q;
		cmd_d      = cmd_q;
		blen_d     = blen_q;
		idx_d      = idx_q;
		chk_d      = chk_q;
		len_d      = len_q;
		have_d     = have_q;
		xor_d      = xor_q;
		resp_d     = resp_q;
		in_cnt_d   = in_cnt_q;
		out_cnt_d  = out_cnt_q;
		in_head_d  = in_head_q;
		out_head_d = out_head_q;
		item_d     = item_q;
		res_d      = res_q;
		out_d      = out_q;
		out_v_d    = out_v_q && !out_ready;
		q_take     = 1'b0;
		resp_new   = resp_q;
		ib_we = 1'b0; ib_waddr = in_head_q + in_cnt_q[FIFO_AW-1:0]; ib_wdata = bf_rdata;
		ib_raddr = in_head_q;
		ob_we = 1'b0; ob_waddr = out_head_q + out_cnt_q[FIFO_AW-1:0]; ob_wdata = b;
		ob_raddr = out_head_q;
		bf_we = 1'b0; bf_waddr = BUF_AW'(idx_q); bf_wdata = b;
		bf_raddr = BUF_AW'(idx_q);
		unique case (state_q)
			E_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					item_d = q_item;
				end
			end
			E_EXEC: begin
				res_d = '0;
				if (item_q.is_push && out_cnt_q < CNT_W'(FIFO_DEPTH)) begin
					ob_we         = 1'b1;
					out_cnt_d     = out_cnt_q + 1'b1;
					res_d.push_ok = 1'b1;
				end
				if (item_q.is_pop && in_cnt_q != '0) begin
					in_head_d       = in_head_q + 1'b1;
					in_cnt_d        = in_cnt_q - 1'b1;
					res_d.pop_valid = 1'b1;
				end
				if (item_q.is_spi) begin
					unique case (phase_q)
						PH_IDLE: begin
							res_d.load = 1'b1;
							if (cmd_ok) begin
								resp_d   = st_now;
								res_d.tx = st_now;
								cmd_d    = b[4:0];
								phase_d  = (b == 8'(CMD_STATUS)) ? PH_END : PH_RESP;
							end
							if (rd_ok) begin
								idx_d = '0;
								xor_d = '0;
							end
						end
						PH_RESP: begin
							unique case (cmd_q)
								CMD_SETLEN: begin
									res_d.load = 1'b1;
									phase_d    = PH_SETLEN;
								end
								CMD_WRITE: begin
									idx_d   = '0;
									xor_d   = '0;
									phase_d = PH_WDATA;
								end
								CMD_READ: begin
									bf_raddr   = '0;
									res_d.load = 1'b1;
									idx_d      = LEN_W'(1);
									phase_d    = PH_RDATA;
								end
								default: begin
									cmd_d   = CMD_NONE;
									phase_d = PH_IDLE;
								end
							endcase
						end
						PH_SETLEN: begin
							if (len_ok) begin
								blen_d   = b[LEN_W-1:0];
								len_d    = 1'b0;
								resp_new = resp_q & ~ST_LEN_ERR;
							end else begin
								len_d    = 1'b1;
								resp_new = resp_q | ST_LEN_ERR;
							end
							resp_d     = resp_new;
							res_d.tx   = resp_new;
							res_d.load = 1'b1;
							phase_d    = PH_END;
						end
						PH_WDATA: begin
							bf_we = 1'b1;
							if (!wlast) begin
								xor_d = xor_q ^ b;
								idx_d = idx_q + 1'b1;
							end else begin
								bf_waddr = BUF_AW'(blen_q);
								if (match) begin
									chk_d    = 1'b0;
									resp_new = resp_q & ~ST_CHK_ERR;
									idx_d    = '0;
								end else begin
									chk_d    = 1'b1;
									resp_new = resp_q | ST_CHK_ERR;
								end
								resp_d     = resp_new;
								res_d.tx   = resp_new;
								res_d.load = 1'b1;
								phase_d    = PH_END;
							end
						end
						PH_RDATA: begin
							bf_raddr   = BUF_AW'(k);
							res_d.load = 1'b1;
							if (k == blen_q) phase_d = PH_RTAIL;
							else idx_d = k + 1'b1;
						end
						PH_RTAIL: begin
							res_d.load = 1'b1;
							phase_d    = PH_MSTAT;
						end
						default: begin
							res_d.notify = (cmd_q == CMD_WRITE) && !chk_q;
							cmd_d        = CMD_NONE;
							phase_d      = PH_IDLE;
						end
					endcase
				end
			end
			E_POPRD: res_d.pop_byte = ib_rdata;
			E_BUFRD: res_d.tx = bf_rdata;
			E_FILL_RD: begin
				if (idx_q == blen_q) begin
					bf_we    = 1'b1;
					bf_waddr = BUF_AW'(blen_q);
					bf_wdata = xor_q;
				end else if (out_cnt_q != '0) begin
					out_head_d = out_head_q + 1'b1;
					out_cnt_d  = out_cnt_q - 1'b1;
					have_d     = 1'b1;
				end else begin
					have_d = 1'b0;
				end
			end
			E_FILL_WR: begin
				bf_we    = 1'b1;
				bf_wdata = fill_v;
				xor_d    = xor_q ^ fill_v;
				idx_d    = idx_q + 1'b1;
			end
			E_APP_RD: ;
			E_APP_WR: begin
				if (in_cnt_q < CNT_W'(FIFO_DEPTH)) begin
					ib_we    = 1'b1;
					in_cnt_d = in_cnt_q + 1'b1;
				end
				idx_d = idx_q + 1'b1;
			end
			E_DONE: begin
				if (!out_v_q || out_ready) begin
					out_d       = res_q;
					out_d.level = LEVEL_W'(in_cnt_q);
					out_v_d     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= E_IDLE;
			phase_q    <= PH_IDLE;
			cmd_q      <= CMD_NONE;
			blen_q     <= LEN_DEFAULT;
			idx_q      <= '0;
			chk_q      <= 1'b0;
			len_q      <= 1'b0;
			have_q     <= 1'b0;
			xor_q      <= '0;
			resp_q     <= '0;
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			in_head_q  <= '0;
			out_head_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			cmd_q      <= cmd_d;
			blen_q     <= blen_d;
			idx_q      <= idx_d;
			chk_q      <= chk_d;
			len_q      <= len_d;
			have_q     <= have_d;
			xor_q      <= xor_d;
			resp_q     <= resp_d;
			in_cnt_q   <= in_cnt_d;
			out_cnt_q  <= out_cnt_d;
			in_head_q  <= in_head_d;
			out_head_q <= out_head_d;
			out_v_q    <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		res_q  <= res_d;
		out_q  <= out_d;
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
endmodule

/* design/spi_slave_block_bridge_core.sv */
// Top level of the SPI slave block bridge: front queue, command engine, ports.
// Depends on ssbb_pkg, ssbb_front, ssbb_back and the assertion header.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tuser: operation, s_tdata: data_byte
// m_*      out  m_tvalid/m_tready   m_tdata: result fields, see port comment
//
// Push, status and most SPI bytes go from queue to result register through
// E_EXEC and E_DONE; pops and read-block bytes add a registered RAM read
// (E_POPRD, E_BUFRD). An accepted read command walks the outbound FIFO into
// the block buffer byte by byte (E_FILL_RD, E_FILL_WR); a good write block is
// copied into the inbound FIFO likewise. The engine handles one item at a time.
// Reset clears counters, pointers and phase; FIFO RAMs need no clearing.
// The two-entry front queue keeps taking transfers while a result stalls, until full.
`include "spi_slave_block_bridge_core_defines.svh"
module spi_slave_block_bridge_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] spi_tx_byte, [8] spi_tx_load, [16:9] pop_byte, [17] pop_valid,
	// [18] push_accepted, [19] rx_notify, [30:20] inbound_level, [31] zero
	output logic [31:0] m_tdata
);
	import ssbb_pkg::*;

	logic  q_valid, q_take;
	item_t q_item;
	res_t  res;

	// front: accept and classify, decouples input from engine stalls
	ssbb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_op(s_tuser), .in_data(s_tdata),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	// back: command engine with FIFOs and block buffer
	ssbb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {1'b0, res.level, res.notify, res.push_ok, res.pop_valid,
		res.pop_byte, res.load, res.tx};

	// a result carries at most one kind of event
	`SSBB_ASSERT_IMPL(a_one_event, clk, arst_n, m_tvalid, $countones(m_tdata[19:17]) + m_tdata[8] <= 1)
	// unloaded tx byte reads zero
	`SSBB_ASSERT_IMPL(a_tx_zero, clk, arst_n, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'h00)
	// failed pop gives zero
	`SSBB_ASSERT_IMPL(a_pop_zero, clk, arst_n, m_tvalid && !m_tdata[17], m_tdata[16:9] == 8'h00)
	// level never exceeds the FIFO depth
	`SSBB_ASSERT_IMPL(a_level, clk, arst_n, m_tvalid, m_tdata[30:20] <= 11'(FIFO_DEPTH))
endmodule
